// ===== rtl/ckx_pkg.sv =====
// ---------------------------------------------------------------------------
// ckx_pkg
// Shared types and constants for the canonical k-mer extractor.
// ---------------------------------------------------------------------------
package ckx_pkg;

   localparam int CHAR_W     = 8;
   localparam int KLEN_W     = 7;
   localparam int HALF_W     = 64;
   localparam int BASE_W     = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = 1;
   localparam int QCNT_W     = 2;

   localparam logic [KLEN_W-1:0] KLEN_RESET = 7'd64;

   localparam logic [CHAR_W-1:0] ASCII_A_UP = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_C_UP = 8'h43;
   localparam logic [CHAR_W-1:0] ASCII_G_UP = 8'h47;
   localparam logic [CHAR_W-1:0] ASCII_T_UP = 8'h54;
   localparam logic [CHAR_W-1:0] ASCII_A_LO = 8'h61;
   localparam logic [CHAR_W-1:0] ASCII_C_LO = 8'h63;
   localparam logic [CHAR_W-1:0] ASCII_G_LO = 8'h67;
   localparam logic [CHAR_W-1:0] ASCII_T_LO = 8'h74;

   localparam logic [BASE_W-1:0] CODE_A = 2'd0;
   localparam logic [BASE_W-1:0] CODE_C = 2'd1;
   localparam logic [BASE_W-1:0] CODE_G = 2'd2;
   localparam logic [BASE_W-1:0] CODE_T = 2'd3;

   typedef struct packed {
      logic              new_seq;
      logic              is_base;
      logic [BASE_W-1:0] code;
   } ckx_entry_type;

   typedef struct packed {
      logic              write;
      logic [KLEN_W-1:0] data;
   } ckx_csr_type;

endpackage

// ===== rtl/ckx_req_if.sv =====
// ---------------------------------------------------------------------------
// ckx_req_if
// Sequence character channel: one ASCII character per beat.
// ---------------------------------------------------------------------------
interface ckx_req_if import ckx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] base_char;
   logic              new_sequence;

   modport source (output valid, base_char, new_sequence, input ready);
   modport sink   (input valid, base_char, new_sequence, output ready);
endinterface

// ===== rtl/ckx_rsp_if.sv =====
// ---------------------------------------------------------------------------
// ckx_rsp_if
// Canonical k-mer channel: one 128-bit k-mer per beat, as two halves.
// ---------------------------------------------------------------------------
interface ckx_rsp_if import ckx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] kmer_hi;
   logic [HALF_W-1:0] kmer_lo;

   modport source (output valid, kmer_hi, kmer_lo, input ready);
   modport sink   (input valid, kmer_hi, kmer_lo, output ready);
endinterface

// ===== rtl/ckx_front.sv =====
// ---------------------------------------------------------------------------
// ckx_front
// Accepts characters, decodes them to 2-bit base codes and holds them in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
module ckx_front import ckx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   ckx_req_if.sink       req_bus,
   output ckx_entry_type q_entry,
   output logic          q_valid,
   input  logic          q_pop
);

   ckx_entry_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;
   ckx_entry_type             decoded;
   logic                      push;
   logic                      pop;

   always_comb begin
      decoded.new_seq = req_bus.new_sequence;
      decoded.is_base = 1'b1;
      decoded.code    = CODE_A;
      case (req_bus.base_char)
         ASCII_A_UP, ASCII_A_LO: decoded.code = CODE_A;
         ASCII_C_UP, ASCII_C_LO: decoded.code = CODE_C;
         ASCII_G_UP, ASCII_G_LO: decoded.code = CODE_G;
         ASCII_T_UP, ASCII_T_LO: decoded.code = CODE_T;
         default:                decoded.is_base = 1'b0;
      endcase
   end

   assign req_bus.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign q_valid       = (count_ff != '0);
   assign pop           = q_pop && q_valid;
   assign q_entry       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count over depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

// ===== rtl/ckx_back.sv =====
// ---------------------------------------------------------------------------
// ckx_back
// Rolling forward and reverse-complement windows, run count, canonical
// select and the result register.
// ---------------------------------------------------------------------------
module ckx_back import ckx_pkg::*; #(
   parameter int MAX_K = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  ckx_csr_type   csr,
   input  ckx_entry_type q_entry,
   input  logic          q_valid,
   output logic          q_pop,
   ckx_rsp_if.source     rsp_bus
);

   localparam int WIN_W = 2 * MAX_K;
   localparam int RUN_W = $clog2(MAX_K + 1);

   logic [KLEN_W-1:0]   kmer_length_ff;
   logic [WIN_W-1:0]    fwd_ff, fwd_in;
   logic [WIN_W-1:0]    rev_ff, rev_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2*HALF_W-1:0] rsp_kmer_ff;

   logic [KLEN_W-1:0]   k_eff7;
   logic [RUN_W-1:0]    k_eff;
   logic [WIN_W-1:0]    fwd_base, rev_base, fwd_shift, rev_shift, canon;
   logic [RUN_W-1:0]    run_base, run_next;
   logic [BASE_W-1:0]   comp;
   logic                slot_free;
   logic                emit;

   always_comb begin
      if (kmer_length_ff == '0) begin
         k_eff7 = KLEN_W'(1);
      end else if (kmer_length_ff > KLEN_W'(MAX_K)) begin
         k_eff7 = KLEN_W'(MAX_K);
      end else begin
         k_eff7 = kmer_length_ff;
      end
   end
   assign k_eff = k_eff7[RUN_W-1:0];

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign q_pop     = q_valid && slot_free;

   assign fwd_base  = q_entry.new_seq ? '0 : fwd_ff;
   assign rev_base  = q_entry.new_seq ? '0 : rev_ff;
   assign run_base  = q_entry.new_seq ? '0 : run_ff;
   assign fwd_shift = WIN_W'({fwd_base, q_entry.code});
   assign rev_shift = rev_base >> 2;
   assign comp      = CODE_T - q_entry.code;

   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         if (RUN_W'(j + 1) == k_eff) begin
            fwd_in[2*j +: 2] = fwd_shift[2*j +: 2];
            rev_in[2*j +: 2] = comp;
         end else if (RUN_W'(j) < k_eff) begin
            fwd_in[2*j +: 2] = fwd_shift[2*j +: 2];
            rev_in[2*j +: 2] = rev_shift[2*j +: 2];
         end else begin
            fwd_in[2*j +: 2] = '0;
            rev_in[2*j +: 2] = '0;
         end
      end
      run_next = (run_base < k_eff) ? run_base + 1'b1 : run_base;
      run_in   = q_entry.is_base ? run_next : '0;
      emit     = q_entry.is_base && (run_next >= k_eff);
      canon    = (rev_in < fwd_in) ? rev_in : fwd_in;
   end

   assign rsp_valid_in = slot_free ? (q_pop && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= KLEN_RESET;
         fwd_ff         <= '0;
         rev_ff         <= '0;
         run_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr.write) begin
            kmer_length_ff <= csr.data;
            fwd_ff         <= '0;
            rev_ff         <= '0;
            run_ff         <= '0;
         end else if (q_pop) begin
            fwd_ff <= q_entry.is_base ? fwd_in : '0;
            rev_ff <= q_entry.is_base ? rev_in : '0;
            run_ff <= run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_kmer_ff <= (2*HALF_W)'(canon);
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.kmer_hi = rsp_kmer_ff[2*HALF_W-1:HALF_W];
   assign rsp_bus.kmer_lo = rsp_kmer_ff[HALF_W-1:0];

   a_csr_clears_run: assert property (@(posedge clock) disable iff (reset)
      csr.write |=> run_ff == '0)
      else $error("run not cleared by length write");

   a_bad_char_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_entry.is_base && !csr.write) |=> (run_ff == '0 && fwd_ff == '0))
      else $error("window not cleared by invalid character");

endmodule

// ===== rtl/canonical_kmer_extractor.sv =====
// ---------------------------------------------------------------------------
// canonical_kmer_extractor
// Streams DNA characters and emits the canonical 2-bit packed k-mer.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus  : one ASCII character per beat with a new_sequence flag.
//              ACGT/acgt are bases; anything else clears the window.
//   rsp_bus  : one canonical k-mer per beat, kmer_hi/kmer_lo, last base in
//              kmer_lo[1:0]; bits at and above 2k are zero.
//   csr_*    : write of k (0 acts as 1, values above MAX_K act as MAX_K);
//              every write also clears the window. Write only when idle.
//   Throughput: one character per cycle, sustained while the receiver does
//   not stall. The window update and the 128-bit forward/reverse compare are combinational.
//   Path: an accepted character is written to the queue, then read out and
//   its result loaded into the result register that drives rsp_bus.
//   A result appears only once k consecutive bases have been seen.
//   Reset: queue empty, window and run cleared, k = 64.
//   Receiver stall: the result register holds, the back end stops, and the
//   two-entry queue fills before req_bus.ready drops.
// ---------------------------------------------------------------------------
module canonical_kmer_extractor import ckx_pkg::*; #(
   parameter int MAX_K = 64
) (
   input  logic              clock,
   input  logic              reset,
   ckx_req_if.sink           req_bus,
   ckx_rsp_if.source         rsp_bus,
   input  logic              csr_write_enable,
   input  logic [KLEN_W-1:0] csr_write_data
);

   ckx_entry_type q_entry;
   ckx_csr_type   csr;
   logic          q_valid;
   logic          q_pop;

   assign csr.write = csr_write_enable;
   assign csr.data  = csr_write_data;

   ckx_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_entry (q_entry),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   ckx_back #(
      .MAX_K (MAX_K)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .q_entry (q_entry),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
